/* design/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH = 8;                    // number of cells, 2 to 15
   localparam int CNT_W = $clog2(DEPTH + 1);    // occupancy counter width

   localparam logic       FUNC_ENQ = 1'b0;
   localparam logic       FUNC_DEQ = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic               func;
      logic signed [31:0] entry_value;
      logic signed [15:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic signed [15:0] removed_priority;
      logic [3:0]         count;
   } rsp_type;

   // contents of one cell
   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      logic signed [15:0] prio;
   } slot_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic               enq;
      logic               deq;
      logic signed [31:0] value;
      logic signed [15:0] prio;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry and, on a command, takes the new
// entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire slot_type     left_slot,   // head cell sees a valid, unbeaten left
   input  wire logic         left_beat,
   input  wire slot_type     right_slot,  // last cell sees an empty right
   output      slot_type     slot,
   output      logic         beat
);

   logic               valid_ff,    valid_in;
   logic signed [31:0] value_ff,    value_in;
   logic signed [15:0] priority_ff, priority_in;

   // new entry outranks the held one
   assign beat = valid_ff && ($signed(cmd.prio) > $signed(priority_ff));

   always_comb begin
      valid_in    = valid_ff;
      value_in    = value_ff;
      priority_in = priority_ff;
      if (cmd.deq) begin
         valid_in    = right_slot.valid;
         value_in    = right_slot.value;
         priority_in = right_slot.prio;
      end else if (cmd.enq) begin
         if (left_beat) begin
            // left entry moves down one place
            valid_in    = left_slot.valid;
            value_in    = left_slot.value;
            priority_in = left_slot.prio;
         end else if ((beat || !valid_ff) && left_slot.valid) begin
            valid_in    = 1'b1;
            value_in    = cmd.value;
            priority_in = cmd.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign slot = '{valid: valid_ff, value: value_ff, prio: priority_ff};

endmodule
`default_nettype wire

/* design/sorted_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in a row of cells sorted by descending
// priority; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            req_data (func, entry_value, entry_priority)
//  response  rsp_strobe             rsp_data (status, removed value/priority, count)
//
//  one transaction per cycle: every cell compares the new priority in parallel
//  and shifts in the same cycle; the response strobes in the cycle after accept.
//  busy is high during reset and in the first cycle after it.
//  synchronous reset empties the queue; cell contents are not cleared.
//  the receiver cannot stall, so responses are never held back.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   logic             busy_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             full;
   logic             empty;
   cell_cmd_type     cmd;
   slot_type         slots [DEPTH];
   logic             beats [DEPTH];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   assign cmd.enq   = accept && (req_data.func == FUNC_ENQ) && !full;
   assign cmd.deq   = accept && (req_data.func == FUNC_DEQ) && !empty;
   assign cmd.value = req_data.entry_value;
   assign cmd.prio  = req_data.entry_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type left_slot;
      logic     left_beat;
      slot_type right_slot;

      if (i == 0) begin : g_head
         assign left_slot = '{valid: 1'b1, value: '0, prio: '0};
         assign left_beat = 1'b0;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_beat = beats[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_slot = '{valid: 1'b0, value: '0, prio: '0};
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_beat  (left_beat),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .beat       (beats[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_data_in.status           = ST_DONE;
      rsp_data_in.removed_value    = '0;
      rsp_data_in.removed_priority = '0;
      rsp_data_in.count            = 4'(count_in);
      if (req_data.func == FUNC_ENQ) begin
         if (full) begin
            rsp_data_in.status = ST_FULL;
         end
      end else if (empty) begin
         rsp_data_in.status = ST_EMPTY;
      end else begin
         rsp_data_in.removed_value    = slots[0].value;
         rsp_data_in.removed_priority = slots[0].prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTH
   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH-1:0] order_ok;

   for (genvar j = 0; j < DEPTH; j++) begin : g_chk
      assign valid_vec[j] = slots[j].valid;
      if (j == 0) begin : g_first
         assign order_ok[j] = 1'b1;
      end else begin : g_rest
         assign order_ok[j] = !slots[j].valid || (slots[j-1].valid
            && ($signed(slots[j-1].prio) >= $signed(slots[j].prio)));
      end
   end

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(valid_vec)) == count_ff)
      else $error("occupancy count disagrees with valid cells");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("cells not packed in descending priority order");

   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("response strobe without an accepted transaction");

   a_deq_reports_head: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> rsp_data.removed_priority == $past(slots[0].prio))
      else $error("dequeue did not report the head entry");
`endif

endmodule
`default_nettype wire

/* tb/tb_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives enqueue and dequeue commands into the sorted priority queue, keeps
// a shadow copy of the queue to work out each response, and checks every
// strobed response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT = 40000;
   localparam int RANDOM_OPS  = 550;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // shadow copy of the queue contents, head in entry 0
   logic signed [31:0] shadow_val [DEPTH];
   logic signed [15:0] shadow_pri [DEPTH];
   int                 shadow_held;

   rsp_type due_rsp[$];
   int      err_count;
   int      cycle_count;
   int      n_enq_done, n_deq_done, n_refused_full, n_refused_empty;
   bit      idle_on;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // applies one command to the shadow queue and returns the response it owes
   function automatic rsp_type apply_queue_op(req_type cmd);
      rsp_type rsp;
      int      pos;
      rsp = '0;
      if (cmd.func == FUNC_ENQ) begin
         if (shadow_held >= DEPTH) begin
            rsp.status = ST_FULL;
            n_refused_full++;
         end else begin
            pos = shadow_held;
            // new entry goes behind every entry of equal or higher priority
            while (pos > 0 && cmd.entry_priority > shadow_pri[pos-1]) begin
               shadow_val[pos] = shadow_val[pos-1];
               shadow_pri[pos] = shadow_pri[pos-1];
               pos--;
            end
            shadow_val[pos] = cmd.entry_value;
            shadow_pri[pos] = cmd.entry_priority;
            shadow_held++;
            rsp.status = ST_DONE;
            n_enq_done++;
         end
      end else begin
         if (shadow_held == 0) begin
            rsp.status = ST_EMPTY;
            n_refused_empty++;
         end else begin
            rsp.removed_value    = shadow_val[0];
            rsp.removed_priority = shadow_pri[0];
            for (int i = 0; i + 1 < shadow_held; i++) begin
               shadow_val[i] = shadow_val[i+1];
               shadow_pri[i] = shadow_pri[i+1];
            end
            shadow_held--;
            rsp.status = ST_DONE;
            n_deq_done++;
         end
      end
      rsp.count = 4'(shadow_held);
      return rsp;
   endfunction

   // one command transaction; start stays high when the next one follows at once
   task automatic send_cmd(input logic func, input logic signed [31:0] value,
                           input logic signed [15:0] prio);
      req_type cmd;
      cmd.func           = func;
      cmd.entry_value    = value;
      cmd.entry_priority = prio;
      if (idle_on && $urandom_range(99) < 38) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
      start    <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      due_rsp.push_back(apply_queue_op(cmd));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_rsp.size());
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_rsp.size() == 0) begin
            $error("response with no transaction outstanding: %p", rsp_data);
            err_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.removed_value !== want.removed_value) begin
               $error("removed_value: expected %0d, got %0d",
                      want.removed_value, rsp_data.removed_value);
               err_count++;
            end
            if (rsp_data.removed_priority !== want.removed_priority) begin
               $error("removed_priority: expected %0d, got %0d",
                      want.removed_priority, rsp_data.removed_priority);
               err_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_data.count);
               err_count++;
            end
         end
      end
   end

   task automatic test_empty_dequeue();
      send_cmd(FUNC_DEQ, 32'sh1234_5678, 16'sh0101);
   endtask

   // fills with extreme values and ties, hits full, then drains past empty
   task automatic test_fill_and_drain();
      send_cmd(FUNC_ENQ, 32'sh7FFF_FFFF, 16'sh0000);
      send_cmd(FUNC_ENQ, 32'sh8000_0000, 16'sh8000);
      send_cmd(FUNC_ENQ, 32'sh0000_0001, 16'sh7FFF);
      send_cmd(FUNC_ENQ, 32'shFFFF_FFFF, 16'sh0000);
      send_cmd(FUNC_ENQ, 32'sh0000_0000, 16'shFFFF);
      send_cmd(FUNC_ENQ, 32'sh5555_5555, 16'sh7FFF);
      send_cmd(FUNC_ENQ, 32'shAAAA_AAAA, 16'sh8000);
      send_cmd(FUNC_ENQ, 32'sh0000_0002, 16'sh0000);
      send_cmd(FUNC_ENQ, 32'sh0000_007B, 16'sh7FFF);
      send_cmd(FUNC_ENQ, 32'shFFFF_FFFB, 16'sh8000);
      repeat (DEPTH + 1) send_cmd(FUNC_DEQ, '0, '0);
   endtask

   // phases that lean toward filling or draining so both limits recur often
   task automatic test_random_ops();
      int                 enq_pct;
      logic signed [15:0] prio;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       enq_pct = 80;
               1:       enq_pct = 25;
               default: enq_pct = 55;
            endcase
         end
         idle_on = !(n >= 200 && n < 330);
         case ($urandom_range(3))
            0:       prio = 16'($signed($urandom_range(4)) - 2);
            1:       prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: prio = 16'($urandom);
         endcase
         if ($urandom_range(99) < enq_pct)
            send_cmd(FUNC_ENQ, 32'($urandom), prio);
         else
            send_cmd(FUNC_DEQ, 32'($urandom), prio);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      err_count   = 0;
      cycle_count = 0;
      shadow_held = 0;
      idle_on     = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_dequeue();
      test_fill_and_drain();
      test_random_ops();

      start <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d enqueues and %0d dequeues that completed,",
               n_enq_done, n_deq_done);
      $display("plus %0d enqueues refused as full and %0d dequeues refused as empty",
               n_refused_full, n_refused_empty);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
